### design/rtt_pkg.sv
package rtt_pkg;

   // Frame geometry
   localparam int MIN_FRAME_BYTES      = 60;
   localparam int MIN_VLAN_FRAME_BYTES = 64;
   localparam int TRAILER_BYTES        = 6;
   localparam int PLAIN_HDR_BYTES      = 14;
   localparam int VLAN_HDR_BYTES       = 18;

   localparam int COUNT_W     = 12;
   localparam int MAX_MIN_LEN = (MIN_FRAME_BYTES > MIN_VLAN_FRAME_BYTES) ?
                                MIN_FRAME_BYTES : MIN_VLAN_FRAME_BYTES;
   localparam int PAD_W       = $clog2(MAX_MIN_LEN + 1);
   localparam int TRL_IDX_W   = 3;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // Request queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Trailer byte positions
   localparam logic [TRL_IDX_W-1:0] TRL_SEQ_HI  = 3'd0;
   localparam logic [TRL_IDX_W-1:0] TRL_SEQ_LO  = 3'd1;
   localparam logic [TRL_IDX_W-1:0] TRL_LAN_HI  = 3'd2;
   localparam logic [TRL_IDX_W-1:0] TRL_SIZE_LO = 3'd3;
   localparam logic [TRL_IDX_W-1:0] TRL_SUF_HI  = 3'd4;
   localparam logic [TRL_IDX_W-1:0] TRL_SUF_LO  = 3'd5;

   // Register map (index = paddr / 4)
   localparam int CSR_ADDR_W = 5;
   localparam logic [2:0] REG_LAN_A_ID   = 3'd0;
   localparam logic [2:0] REG_LAN_B_ID   = 3'd1;
   localparam logic [2:0] REG_PORT_A_UP  = 3'd2;
   localparam logic [2:0] REG_PORT_B_UP  = 3'd3;
   localparam logic [2:0] REG_SUFFIX     = 3'd4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte_a;
      logic [7:0] out_byte_b;
      logic       send_a;
      logic       send_b;
      logic       frame_end;
      logic       frame_error;
   } rsp_payload_type;

   typedef struct packed {
      logic [3:0]  lan_a_id;
      logic [3:0]  lan_b_id;
      logic        port_a_up;
      logic        port_b_up;
      logic [15:0] trailer_suffix;
   } cfg_type;

   typedef enum logic [1:0] {
      KIND_BYTE,
      KIND_SHORT_END,
      KIND_GOOD_END
   } kind_type;

   typedef struct packed {
      kind_type             kind;
      logic [7:0]           data_byte;
      logic [PAD_W-1:0]     pad_count;
      logic [COUNT_W-1:0]   lsdu;
      logic [15:0]          seq;
   } entry_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_PAD,
      BACK_TRAILER
   } back_state_type;

endpackage

### design/redundancy_trailer_tagger.sv
// Duplicating transmitter that tags each outgoing frame with a redundancy
// control trailer. Frame bytes enter on the req_ channel, one per request,
// header first, with last_byte marking the end of the frame. Each request
// leaves as one result on the rsp_ channel carrying both LAN copies side by
// side; send_a / send_b follow the port-up registers. On a good last byte the
// block then emits zero padding up to the minimum length (plain or VLAN) and
// the 6-byte trailer, with frame_end on the final trailer byte. A frame
// shorter than its header ends on its last byte, flagged with frame_end
// and frame_error, with no padding or trailer. Registers sit on the csr_
// port at byte addresses 4*i. A request passes the request queue, then the
// output register; bytes go out one per cycle while rsp_stall is low. During
// the padding and trailer burst of a frame end the 4-entry request queue
// between front and back takes up to 4 more requests, then req_stall rises
// until the burst is out. rsp_stall holds the output register; the queue
// keeps accepting until it is full. Reset (synchronous) sets the sequence
// number to 0, restores the register defaults and empties the queue.
module redundancy_trailer_tagger (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  rtt_pkg::req_payload_type             req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output rtt_pkg::rsp_payload_type             rsp_payload,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [rtt_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [31:0]                          csr_pwdata,
   output logic [31:0]                          csr_prdata,
   output logic                                 csr_pready
);
   import rtt_pkg::*;

   cfg_type    cfg_ff;
   logic       cfg_write;
   logic [2:0] reg_index;
   logic       queue_full, queue_not_empty, push, pop;
   entry_type  push_entry, head;

   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_index  = csr_paddr[4:2];
   assign req_stall  = queue_full;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lan_a_id       <= 4'd10;
         cfg_ff.lan_b_id       <= 4'd11;
         cfg_ff.port_a_up      <= 1'b1;
         cfg_ff.port_b_up      <= 1'b1;
         cfg_ff.trailer_suffix <= 16'h88FB;
      end else if (cfg_write) begin
         case (reg_index)
            REG_LAN_A_ID:  cfg_ff.lan_a_id       <= csr_pwdata[3:0];
            REG_LAN_B_ID:  cfg_ff.lan_b_id       <= csr_pwdata[3:0];
            REG_PORT_A_UP: cfg_ff.port_a_up      <= csr_pwdata[0];
            REG_PORT_B_UP: cfg_ff.port_b_up      <= csr_pwdata[0];
            REG_SUFFIX:    cfg_ff.trailer_suffix <= csr_pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   // Read back configuration registers
   always_comb begin
      case (reg_index)
         REG_LAN_A_ID:  csr_prdata = {28'd0, cfg_ff.lan_a_id};
         REG_LAN_B_ID:  csr_prdata = {28'd0, cfg_ff.lan_b_id};
         REG_PORT_A_UP: csr_prdata = {31'd0, cfg_ff.port_a_up};
         REG_PORT_B_UP: csr_prdata = {31'd0, cfg_ff.port_b_up};
         REG_SUFFIX:    csr_prdata = {16'd0, cfg_ff.trailer_suffix};
         default:       csr_prdata = 32'd0;
      endcase
   end

   rtt_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_payload (req_payload),
      .queue_full  (queue_full),
      .push        (push),
      .push_entry  (push_entry)
   );

   rtt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (queue_full),
      .not_empty  (queue_not_empty),
      .head       (head)
   );

   rtt_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .not_empty   (queue_not_empty),
      .head        (head),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // A short-frame flag only comes with the frame end
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.frame_error |-> rsp_payload.frame_end)
      else $error("frame_error without frame_end");

   // A flagged byte is a pass-through byte, identical in both copies
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.frame_error |->
         rsp_payload.out_byte_a == rsp_payload.out_byte_b)
      else $error("flagged byte differs between copies");

   // Reset leaves the queue empty and the output idle
   assert property (@(posedge clock)
      reset |=> !req_stall && !rsp_valid)
      else $error("block not empty after reset");

endmodule

### design/rtt_front.sv
module rtt_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  rtt_pkg::req_payload_type req_payload,
   input  logic                     queue_full,
   output logic                     push,
   output rtt_pkg::entry_type       push_entry
);
   import rtt_pkg::*;

   localparam logic [COUNT_W-1:0] MIN_LEN      = COUNT_W'(MIN_FRAME_BYTES);
   localparam logic [COUNT_W-1:0] MIN_VLAN_LEN = COUNT_W'(MIN_VLAN_FRAME_BYTES);
   localparam logic [COUNT_W-1:0] PLAIN_HDR    = COUNT_W'(PLAIN_HDR_BYTES);
   localparam logic [COUNT_W-1:0] VLAN_HDR     = COUNT_W'(VLAN_HDR_BYTES);
   localparam logic [COUNT_W-1:0] TRL_LEN      = COUNT_W'(TRAILER_BYTES);

   logic [COUNT_W-1:0] byte_count_ff, byte_count_in;
   logic               type_high_ff, type_high_in;
   logic               vlan_ff, vlan_in;
   logic [15:0]        seq_ff, seq_in;

   logic [COUNT_W-1:0] count, header, min_len, padded;
   logic               need_pad;

   assign push = req_valid && !queue_full;

   // Classify the byte against the header position
   always_comb begin
      type_high_in = (byte_count_ff == COUNT_W'(12)) ?
                     (req_payload.data_byte == 8'h81) : type_high_ff;
      vlan_in      = (byte_count_ff == COUNT_W'(13)) ?
                     (type_high_ff && req_payload.data_byte == 8'h00) : vlan_ff;
      count        = (byte_count_ff != COUNT_MAX) ? byte_count_ff + 1'b1 : COUNT_MAX;
      header       = vlan_in ? VLAN_HDR : PLAIN_HDR;
      min_len      = vlan_in ? MIN_VLAN_LEN : MIN_LEN;
      need_pad     = count < min_len;
      padded       = need_pad ? min_len : count;
   end

   // Build the queue entry
   always_comb begin
      push_entry.data_byte = req_payload.data_byte;
      push_entry.seq       = seq_ff;
      push_entry.lsdu      = padded + TRL_LEN - header;
      push_entry.pad_count = need_pad ? PAD_W'(min_len - count) : '0;
      if (!req_payload.last_byte) begin
         push_entry.kind = KIND_BYTE;
      end else if (count < header) begin
         push_entry.kind = KIND_SHORT_END;
      end else begin
         push_entry.kind = KIND_GOOD_END;
      end
   end

   // Advance the frame state on each accepted request
   always_comb begin
      byte_count_in = byte_count_ff;
      seq_in        = seq_ff;
      if (push) begin
         if (req_payload.last_byte) begin
            byte_count_in = '0;
            seq_in        = seq_ff + 16'd1;
         end else begin
            byte_count_in = count;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
         type_high_ff  <= 1'b0;
         vlan_ff       <= 1'b0;
         seq_ff        <= '0;
      end else begin
         byte_count_ff <= byte_count_in;
         seq_ff        <= seq_in;
         if (push) begin
            type_high_ff <= req_payload.last_byte ? 1'b0 : type_high_in;
            vlan_ff      <= req_payload.last_byte ? 1'b0 : vlan_in;
         end
      end
   end

endmodule

### design/rtt_queue.sv
module rtt_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  rtt_pkg::entry_type push_entry,
   input  logic               pop,
   output logic               full,
   output logic               not_empty,
   output rtt_pkg::entry_type head
);
   import rtt_pkg::*;

   entry_type         mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = mem_ff[rd_ptr_ff];

   // Track occupancy
   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### design/rtt_back.sv
module rtt_back (
   input  logic                     clock,
   input  logic                     reset,
   input  rtt_pkg::cfg_type         cfg,
   input  logic                     not_empty,
   input  rtt_pkg::entry_type       head,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rtt_pkg::rsp_payload_type rsp_payload
);
   import rtt_pkg::*;

   localparam logic [TRL_IDX_W-1:0] TRL_LAST = TRL_IDX_W'(TRAILER_BYTES - 1);

   back_state_type         state_ff, state_in;
   logic [PAD_W-1:0]       pad_ff, pad_in;
   logic [TRL_IDX_W-1:0]   idx_ff, idx_in;
   logic [15:0]            seq_ff, seq_in;
   logic [COUNT_W-1:0]     lsdu_ff, lsdu_in;
   logic                   valid_ff, valid_in;
   rsp_payload_type        payload_ff, payload_in;
   logic                   load;
   logic [7:0]             trl_a, trl_b;

   assign rsp_valid   = valid_ff;
   assign rsp_payload = payload_ff;
   assign load        = !valid_ff || !rsp_stall;

   // Select the trailer byte for each copy
   always_comb begin
      trl_a = 8'h00;
      trl_b = 8'h00;
      case (idx_ff)
         TRL_SEQ_HI: begin
            trl_a = seq_ff[15:8];
            trl_b = seq_ff[15:8];
         end
         TRL_SEQ_LO: begin
            trl_a = seq_ff[7:0];
            trl_b = seq_ff[7:0];
         end
         TRL_LAN_HI: begin
            trl_a = {cfg.lan_a_id, lsdu_ff[11:8]};
            trl_b = {cfg.lan_b_id, lsdu_ff[11:8]};
         end
         TRL_SIZE_LO: begin
            trl_a = lsdu_ff[7:0];
            trl_b = lsdu_ff[7:0];
         end
         TRL_SUF_HI: begin
            trl_a = cfg.trailer_suffix[15:8];
            trl_b = cfg.trailer_suffix[15:8];
         end
         TRL_SUF_LO: begin
            trl_a = cfg.trailer_suffix[7:0];
            trl_b = cfg.trailer_suffix[7:0];
         end
         default: begin
            trl_a = 8'h00;
            trl_b = 8'h00;
         end
      endcase
   end

   // Sequence pass-through, padding and trailer bytes
   always_comb begin
      state_in   = state_ff;
      pad_in     = pad_ff;
      idx_in     = idx_ff;
      seq_in     = seq_ff;
      lsdu_in    = lsdu_ff;
      pop        = 1'b0;
      valid_in   = valid_ff;
      payload_in = payload_ff;
      if (load) begin
         valid_in               = 1'b0;
         payload_in.send_a      = cfg.port_a_up;
         payload_in.send_b      = cfg.port_b_up;
         payload_in.frame_end   = 1'b0;
         payload_in.frame_error = 1'b0;
         case (state_ff)
            BACK_IDLE: begin
               if (not_empty) begin
                  pop                    = 1'b1;
                  valid_in               = 1'b1;
                  payload_in.out_byte_a  = head.data_byte;
                  payload_in.out_byte_b  = head.data_byte;
                  payload_in.frame_end   = (head.kind == KIND_SHORT_END);
                  payload_in.frame_error = (head.kind == KIND_SHORT_END);
                  if (head.kind == KIND_GOOD_END) begin
                     seq_in  = head.seq;
                     lsdu_in = head.lsdu;
                     pad_in  = head.pad_count;
                     idx_in  = '0;
                     state_in = (head.pad_count != '0) ? BACK_PAD : BACK_TRAILER;
                  end
               end
            end
            BACK_PAD: begin
               valid_in              = 1'b1;
               payload_in.out_byte_a = 8'h00;
               payload_in.out_byte_b = 8'h00;
               pad_in                = pad_ff - 1'b1;
               if (pad_ff == PAD_W'(1)) begin
                  state_in = BACK_TRAILER;
               end
            end
            BACK_TRAILER: begin
               valid_in              = 1'b1;
               payload_in.out_byte_a = trl_a;
               payload_in.out_byte_b = trl_b;
               if (idx_ff == TRL_LAST) begin
                  payload_in.frame_end = 1'b1;
                  state_in             = BACK_IDLE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
            default: begin
               state_in = BACK_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BACK_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pad_ff     <= pad_in;
      idx_ff     <= idx_in;
      seq_ff     <= seq_in;
      lsdu_ff    <= lsdu_in;
      payload_ff <= payload_in;
   end

endmodule
